### rtl/mma_pkg.sv
package mma_pkg;

  localparam int MAX_DIM_DEFAULT = 16;
  localparam int DIM_CFG_W = 5;
  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [2:0] {
    FN_LOAD_A  = 3'd0,
    FN_LOAD_B  = 3'd1,
    FN_LOAD_C  = 3'd2,
    FN_COMPUTE = 3'd3,
    FN_READ_C  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    CFG_ROW   = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COL   = 2'd2
  } cfg_reg_t;

  // One step of the float unit per cycle.
  typedef enum logic [3:0] {
    FOP_NONE  = 4'd0,
    FOP_ACC   = 4'd1,
    FOP_MUL   = 4'd2,
    FOP_NL1   = 4'd3,
    FOP_NL2   = 4'd4,
    FOP_NL3   = 4'd5,
    FOP_NR    = 4'd6,
    FOP_RNDP  = 4'd7,
    FOP_ALIGN = 4'd8,
    FOP_SUM   = 4'd9,
    FOP_RNDA  = 4'd10
  } fop_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic wr_c;
    logic host_rd;
    logic out_load;
    logic cp_init;
    logic elem_rd;
    logic adv_k;
    logic wb;
    fop_t fop;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic j_last;
    logic i_last;
  } stat_t;

endpackage

### rtl/matrix_multiply_accumulate.sv
// Channel   Direction  Handshake                 Beat payload
// cfg       in         cfg_write                 cfg_index, cfg_data
// in        in         in_valid / in_stall       func, elem_index, elem_value
// out       out        out_valid / out_stall     read_value, read_index
//
// Loads of A, B and C never stall the next beat; a read does: in_stall holds the next beat
// while ST_RD_WAIT loads the C store data into read_value and sets out_valid.
// Compute holds in_stall from its beat until all of C is written back: every inner step
// runs a multiply and an add through the one shared float unit, one normalize or round step
// per cycle, with one RAM read per step.
// Reset (rst, synchronous, active high) clears control state and sets all sizes to 16;
// the A, B and C stores hold nothing defined until loaded.
// out_stall holds the result beat; a read beat waits while a blocked result is still held,
// loads and compute beats do not.
module matrix_multiply_accumulate #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mma_pkg::DIM_CFG_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    func,
  input  logic [7:0]                    elem_index,
  input  logic [31:0]                   elem_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   read_value,
  output logic [7:0]                    read_index
);

  mma_pkg::cmd_t  cmd;
  mma_pkg::stat_t stat;

  // sequencer: decodes beats, walks the i/j/k loops and steps the float unit
  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // stores, address counters, float unit and the result register
  mma_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .cmd        (cmd),
    .stat       (stat),
    .read_value (read_value),
    .read_index (read_index)
  );

endmodule

### rtl/mma_ram.sv
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mma_fpu.sv
module mma_fpu (
  input  logic          clk,
  input  mma_pkg::fop_t fop,
  input  logic [31:0]   a_in,
  input  logic [31:0]   b_in,
  input  logic [31:0]   c_in,
  output logic [31:0]   acc
);

  localparam logic [31:0] QNAN_DEF  = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

  typedef struct packed {
    logic signed [10:0] e;
    logic [47:0]        m;
  } em_t;

  function automatic logic is_nan(input logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] w);
    return w[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] mant(input logic [31:0] w);
    return {w[30:23] != 8'd0, w[22:0]};
  endfunction

  function automatic logic [7:0] eeff(input logic [31:0] w);
    return (w[30:23] == 8'd0) ? 8'd1 : w[30:23];
  endfunction

  // Shift left by sh if the top sh bits are zero and the exponent stays above zero.
  function automatic em_t nstep(input em_t x, input int unsigned sh);
    em_t r;
    r = x;
    if (((x.m >> (48 - sh)) == 48'd0) && (x.e > $signed(11'(sh)))) begin
      r.m = x.m << sh;
      r.e = x.e - $signed(11'(sh));
    end
    return r;
  endfunction

  logic [31:0]        prod;
  logic               sp_v;
  logic [31:0]        sp_val;
  logic               nr_s;
  logic signed [10:0] nr_e;
  logic [47:0]        nr_m;
  logic               nr_st;
  logic [26:0]        al_mb;
  logic [26:0]        al_ms;
  logic [7:0]         al_e;
  logic               al_sb;
  logic               al_sub;
  logic               al_zs;

  // multiply
  logic [47:0] mul_p;
  logic        mul_s;
  logic        mul_spv;
  logic [31:0] mul_spval;

  always_comb begin
    mul_p     = mant(a_in) * mant(b_in);
    mul_s     = a_in[31] ^ b_in[31];
    mul_spv   = 1'b1;
    mul_spval = QNAN_DEF;
    if (is_nan(a_in)) begin
      mul_spval = a_in | QUIET_BIT;
    end else if (is_nan(b_in)) begin
      mul_spval = b_in | QUIET_BIT;
    end else if ((is_inf(a_in) && is_zero(b_in)) || (is_zero(a_in) && is_inf(b_in))) begin
      mul_spval = QNAN_DEF;
    end else if (is_inf(a_in) || is_inf(b_in)) begin
      mul_spval = {mul_s, 8'hFF, 23'd0};
    end else if (is_zero(a_in) || is_zero(b_in)) begin
      mul_spval = {mul_s, 31'd0};
    end else begin
      mul_spv = 1'b0;
    end
  end

  // left normalize, two shift levels per step
  em_t em_cur;
  em_t nl1;
  em_t nl2;
  em_t nl3;

  always_comb begin
    em_cur = '{e: nr_e, m: nr_m};
    nl1 = nstep(nstep(em_cur, 32), 16);
    nl2 = nstep(nstep(em_cur, 8), 4);
    nl3 = nstep(nstep(em_cur, 2), 1);
  end

  // right shift into the subnormal range
  logic signed [10:0] ramt;
  logic [5:0]         rsh;
  logic [47:0]        rmask;
  logic [47:0]        nr_m_r;
  logic               nr_st_r;

  always_comb begin
    ramt    = 11'sd1 - nr_e;
    rsh     = ramt[5:0];
    rmask   = ~({48{1'b1}} << rsh);
    nr_m_r  = nr_m;
    nr_st_r = nr_st;
    if (nr_e < 11'sd1) begin
      if (ramt > 11'sd47) begin
        nr_m_r  = 48'd0;
        nr_st_r = nr_st | (|nr_m);
      end else begin
        nr_m_r  = nr_m >> rsh;
        nr_st_r = nr_st | (|(nr_m & rmask));
      end
    end
  end

  // round to nearest even and pack
  logic               rg;
  logic               rstk;
  logic               rup;
  logic [24:0]        rr;
  logic signed [10:0] rfe;
  logic [31:0]        rnd_w;
  logic [31:0]        rnd_out;

  always_comb begin
    rg   = nr_m[23];
    rstk = nr_st | (|nr_m[22:0]);
    rup  = rg & (rstk | nr_m[24]);
    rr   = {1'b0, nr_m[47:24]} + {24'd0, rup};
    if (rr[24]) begin
      rfe = nr_e + 11'sd1;
    end else if (rr[23]) begin
      rfe = nr_e;
    end else begin
      rfe = 11'sd0;
    end
    if (rfe >= 11'sd255) begin
      rnd_w = {nr_s, 8'hFF, 23'd0};
    end else begin
      rnd_w = {nr_s, rfe[7:0], rr[24] ? rr[23:1] : rr[22:0]};
    end
    rnd_out = sp_v ? sp_val : rnd_w;
  end

  // align the smaller addend to the larger
  logic        big_x;
  logic [31:0] bw;
  logic [31:0] sw;
  logic [7:0]  ad;
  logic [26:0] asm27;
  logic [26:0] ash;
  logic        ast;
  logic        add_spv;
  logic [31:0] add_spval;

  always_comb begin
    big_x = acc[30:0] >= prod[30:0];
    bw    = big_x ? acc : prod;
    sw    = big_x ? prod : acc;
    ad    = eeff(bw) - eeff(sw);
    asm27 = {mant(sw), 3'b000};
    if (ad >= 8'd27) begin
      ash = 27'd0;
      ast = |asm27;
    end else begin
      ash = asm27 >> ad[4:0];
      ast = |(asm27 & ~({27{1'b1}} << ad[4:0]));
    end
    add_spv   = 1'b1;
    add_spval = QNAN_DEF;
    if (is_nan(acc)) begin
      add_spval = acc | QUIET_BIT;
    end else if (is_nan(prod)) begin
      add_spval = prod | QUIET_BIT;
    end else if (is_inf(acc) && is_inf(prod) && (acc[31] != prod[31])) begin
      add_spval = QNAN_DEF;
    end else if (is_inf(acc)) begin
      add_spval = acc;
    end else if (is_inf(prod)) begin
      add_spval = prod;
    end else begin
      add_spv = 1'b0;
    end
  end

  logic [27:0] sum28;

  always_comb begin
    if (al_sub) begin
      sum28 = {1'b0, al_mb} - {1'b0, al_ms};
    end else begin
      sum28 = {1'b0, al_mb} + {1'b0, al_ms};
    end
  end

  always_ff @(posedge clk) begin
    unique case (fop)
      mma_pkg::FOP_NONE: begin
      end
      mma_pkg::FOP_ACC: begin
        acc <= c_in;
      end
      mma_pkg::FOP_MUL: begin
        sp_v   <= mul_spv;
        sp_val <= mul_spval;
        nr_s   <= mul_s;
        nr_e   <= $signed({3'b000, eeff(a_in)}) + $signed({3'b000, eeff(b_in)}) - 11'sd126;
        nr_m   <= mul_p;
        nr_st  <= 1'b0;
      end
      mma_pkg::FOP_NL1: begin
        nr_e <= nl1.e;
        nr_m <= nl1.m;
      end
      mma_pkg::FOP_NL2: begin
        nr_e <= nl2.e;
        nr_m <= nl2.m;
      end
      mma_pkg::FOP_NL3: begin
        nr_e <= nl3.e;
        nr_m <= nl3.m;
      end
      mma_pkg::FOP_NR: begin
        nr_m  <= nr_m_r;
        nr_st <= nr_st_r;
        if (nr_e < 11'sd1) begin
          nr_e <= 11'sd1;
        end
      end
      mma_pkg::FOP_RNDP: begin
        prod <= rnd_out;
      end
      mma_pkg::FOP_ALIGN: begin
        sp_v   <= add_spv;
        sp_val <= add_spval;
        al_mb  <= {mant(bw), 3'b000};
        al_ms  <= {ash[26:1], ash[0] | ast};
        al_e   <= eeff(bw);
        al_sb  <= bw[31];
        al_sub <= acc[31] ^ prod[31];
        al_zs  <= acc[31] & prod[31];
      end
      mma_pkg::FOP_SUM: begin
        nr_s  <= (sum28 == 28'd0) ? al_zs : al_sb;
        nr_e  <= $signed({3'b000, al_e}) + 11'sd1;
        nr_m  <= {sum28, 20'd0};
        nr_st <= 1'b0;
      end
      mma_pkg::FOP_RNDA: begin
        acc <= rnd_out;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/mma_dp.sv
module mma_dp #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mma_pkg::DIM_CFG_W-1:0] cfg_data,
  input  logic [7:0]                    elem_index,
  input  logic [31:0]                   elem_value,
  input  mma_pkg::cmd_t                 cmd,
  output mma_pkg::stat_t                stat,
  output logic [31:0]                   read_value,
  output logic [7:0]                    read_index
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int IW    = $clog2(MAX_DIM);

  function automatic logic [DW-1:0] clamp_dim(input logic [mma_pkg::DIM_CFG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end
    return DW'(v);
  endfunction

  logic [mma_pkg::DIM_CFG_W-1:0] row_count;
  logic [mma_pkg::DIM_CFG_W-1:0] inner_count;
  logic [mma_pkg::DIM_CFG_W-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= mma_pkg::DIM_RESET;
      inner_count <= mma_pkg::DIM_RESET;
      col_count   <= mma_pkg::DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mma_pkg::CFG_ROW:   row_count   <= cfg_data;
        mma_pkg::CFG_INNER: inner_count <= cfg_data;
        mma_pkg::CFG_COL:   col_count   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [DW-1:0] dim_m;
  logic [DW-1:0] dim_k;
  logic [DW-1:0] dim_n;

  assign dim_m = clamp_dim(row_count);
  assign dim_k = clamp_dim(inner_count);
  assign dim_n = clamp_dim(col_count);

  // loop counters and running addresses
  logic [IW-1:0] ci;
  logic [IW-1:0] cj;
  logic [IW-1:0] ck;
  logic [AW-1:0] a_base;
  logic [AW-1:0] b_addr;
  logic [AW-1:0] c_addr;

  assign stat.k_last = DW'(ck) == (dim_k - DW'(1));
  assign stat.j_last = DW'(cj) == (dim_n - DW'(1));
  assign stat.i_last = DW'(ci) == (dim_m - DW'(1));

  always_ff @(posedge clk) begin
    if (cmd.cp_init) begin
      ci     <= '0;
      cj     <= '0;
      ck     <= '0;
      a_base <= '0;
      b_addr <= '0;
      c_addr <= '0;
    end else if (cmd.adv_k) begin
      ck     <= ck + IW'(1);
      b_addr <= b_addr + AW'(dim_n);
    end else if (cmd.wb) begin
      ck     <= '0;
      c_addr <= c_addr + AW'(1);
      if (stat.j_last) begin
        cj     <= '0;
        ci     <= ci + IW'(1);
        a_base <= a_base + AW'(dim_k);
        b_addr <= '0;
      end else begin
        cj     <= cj + IW'(1);
        b_addr <= AW'(cj) + AW'(1);
      end
    end
  end

  logic [AW-1:0] host_addr;
  logic          host_in;

  assign host_addr = AW'(elem_index);
  assign host_in   = 32'(elem_index) < 32'(DEPTH);

  logic [31:0] a_rdata;
  logic [31:0] b_rdata;
  logic [31:0] c_rdata;
  logic [31:0] acc;

  mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a & host_in),
    .waddr (host_addr),
    .wdata (elem_value),
    .re    (cmd.elem_rd),
    .raddr (a_base + AW'(ck)),
    .rdata (a_rdata)
  );

  mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b & host_in),
    .waddr (host_addr),
    .wdata (elem_value),
    .re    (cmd.elem_rd),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_c (
    .clk   (clk),
    .we    ((cmd.wr_c & host_in) | cmd.wb),
    .waddr (cmd.wb ? c_addr : host_addr),
    .wdata (cmd.wb ? acc : elem_value),
    .re    (cmd.elem_rd | cmd.host_rd),
    .raddr (cmd.host_rd ? host_addr : c_addr),
    .rdata (c_rdata)
  );

  mma_fpu u_fpu (
    .clk  (clk),
    .fop  (cmd.fop),
    .a_in (a_rdata),
    .b_in (b_rdata),
    .c_in (c_rdata),
    .acc  (acc)
  );

  // host read: hold index and range flag until the data comes back
  logic       rd_in;
  logic [7:0] rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.host_rd) begin
      rd_in  <= host_in;
      rd_idx <= elem_index;
    end
    if (cmd.out_load) begin
      read_value <= rd_in ? c_rdata : 32'd0;
      read_index <= rd_idx;
    end
  end

endmodule

### rtl/mma_ctrl.sv
module mma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [2:0]     func,
  input  logic           out_stall,
  input  mma_pkg::stat_t stat,
  output logic           in_stall,
  output logic           out_valid,
  output mma_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_CP_RDC,
    ST_CP_ACC,
    ST_MUL,
    ST_NL1,
    ST_NL2,
    ST_NL3,
    ST_NR,
    ST_RNDP,
    ST_ALIGN,
    ST_SUM,
    ST_RNDA,
    ST_CP_RDAB,
    ST_WB
  } state_t;

  state_t state;
  state_t state_next;
  logic   add_phase;
  logic   take;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    take       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = (func == mma_pkg::FN_READ_C) && out_valid && out_stall;
        take     = in_valid && !in_stall;
        if (take) begin
          unique case (func)
            mma_pkg::FN_LOAD_A: cmd.wr_a = 1'b1;
            mma_pkg::FN_LOAD_B: cmd.wr_b = 1'b1;
            mma_pkg::FN_LOAD_C: cmd.wr_c = 1'b1;
            mma_pkg::FN_COMPUTE: begin
              cmd.cp_init = 1'b1;
              state_next  = ST_CP_RDC;
            end
            mma_pkg::FN_READ_C: begin
              cmd.host_rd = 1'b1;
              state_next  = ST_RD_WAIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        cmd.out_load = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_CP_RDC: begin
        cmd.elem_rd = 1'b1;
        state_next  = ST_CP_ACC;
      end
      ST_CP_ACC: begin
        cmd.fop    = mma_pkg::FOP_ACC;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.fop    = mma_pkg::FOP_MUL;
        state_next = ST_NL1;
      end
      ST_NL1: begin
        cmd.fop    = mma_pkg::FOP_NL1;
        state_next = ST_NL2;
      end
      ST_NL2: begin
        cmd.fop    = mma_pkg::FOP_NL2;
        state_next = ST_NL3;
      end
      ST_NL3: begin
        cmd.fop    = mma_pkg::FOP_NL3;
        state_next = ST_NR;
      end
      ST_NR: begin
        cmd.fop    = mma_pkg::FOP_NR;
        state_next = add_phase ? ST_RNDA : ST_RNDP;
      end
      ST_RNDP: begin
        cmd.fop    = mma_pkg::FOP_RNDP;
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.fop    = mma_pkg::FOP_ALIGN;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.fop    = mma_pkg::FOP_SUM;
        state_next = ST_NL1;
      end
      ST_RNDA: begin
        cmd.fop = mma_pkg::FOP_RNDA;
        if (stat.k_last) begin
          state_next = ST_WB;
        end else begin
          cmd.adv_k  = 1'b1;
          state_next = ST_CP_RDAB;
        end
      end
      ST_CP_RDAB: begin
        cmd.elem_rd = 1'b1;
        state_next  = ST_MUL;
      end
      ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = (stat.i_last && stat.j_last) ? ST_IDLE : ST_CP_RDC;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      add_phase <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RD_WAIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_RNDP) begin
        add_phase <= 1'b1;
      end else if (state == ST_RNDA) begin
        add_phase <= 1'b0;
      end
    end
  end

endmodule

### rtl/mma_checker.sv
module mma_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  func,
  input logic [7:0]  elem_index,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] read_value,
  input logic [7:0]  read_index
);

  logic take;
  logic load_take;

  assign take      = in_valid && !in_stall;
  assign load_take = take && ((func == mma_pkg::FN_LOAD_A) || (func == mma_pkg::FN_LOAD_B) ||
                              (func == mma_pkg::FN_LOAD_C));

  // a read beat returns its own index with the result it raises out_valid for
  a_read_echo: assert property (@(posedge clk) disable iff (rst)
    (take && func == mma_pkg::FN_READ_C) |->
      ##2 (out_valid && read_index == $past(elem_index, 2)))
    else $error("read result missing or index wrong");

  // compute holds off the next beat
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (take && func == mma_pkg::FN_COMPUTE) |=> in_stall)
    else $error("beat accepted during compute");

  // loads never make a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (load_take && !out_valid) |=> !out_valid)
    else $error("load produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(read_value) && $stable(read_index)))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mma_pkg::*;

  localparam int STORE_WORDS = 256;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_GOAL = 1450;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] FN_SPARE_5 = 3'd5;
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;

  // Tracks the three element stores and the sizes, and holds the C reads still owed.
  class c_element_tracker;
    logic [31:0] a_mem[STORE_WORDS];
    logic [31:0] b_mem[STORE_WORDS];
    logic [31:0] c_mem[STORE_WORDS];
    logic [4:0] rows_reg, inner_reg, cols_reg;
    logic [31:0] owed_value[$];
    logic [7:0] owed_index[$];
    int errors;

    function new();
      rows_reg = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      errors = 0;
      for (int i = 0; i < STORE_WORDS; i++) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
        c_mem[i] = '0;
      end
    endfunction

    function int dim(logic [4:0] v);
      if (v == 0) return 1;
      if (v > 16) return 16;
      return v;
    endfunction

    function bit is_nan(logic [31:0] w);
      return w[30:23] == 8'hFF && w[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] w);
      return w[30:23] == 8'hFF && w[22:0] == 0;
    endfunction

    function bit is_zero(logic [31:0] w);
      return w[30:0] == 0;
    endfunction

    // Widen a binary32 pattern to a double (exact).
    function real widen(logic [31:0] w);
      logic [23:0] m;
      int ex;
      m = {1'b0, w[22:0]};
      if (w[30:0] == 0) return $bitstoreal({w[31], 63'b0});
      if (w[30:23] == 0) begin
        ex = -126;
        while (!m[23]) begin
          m = m << 1;
          ex--;
        end
      end else begin
        ex = int'(w[30:23]) - 127;
      end
      return $bitstoreal({w[31], 11'(ex + 1023), m[22:0], 29'b0});
    endfunction

    // Round a double to binary32, nearest even, with subnormals.
    function logic [31:0] narrow(real r);
      logic [63:0] d, sig, kept, rest, half;
      int ex, sh;
      d = $realtobits(r);
      if (d[62:52] == 0) return {d[63], 31'b0};
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'b0};
      ex = int'(d[62:52]) - 1023;
      sig = {11'b0, 1'b1, d[51:0]};
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh > 60) sh = 60;
      kept = sig >> sh;
      rest = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0])) kept++;
      if (ex >= -126) begin
        if (kept == (64'd1 << 24)) begin
          kept = kept >> 1;
          ex++;
        end
        if (ex > 127) return {d[63], 8'hFF, 23'b0};
        return {d[63], 8'(ex + 127), kept[22:0]};
      end
      return {d[63], kept[30:0]};
    endfunction

    function logic [31:0] fmul(logic [31:0] x, logic [31:0] y);
      if (is_nan(x)) return x | 32'h00400000;
      if (is_nan(y)) return y | 32'h00400000;
      if ((is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y))) return DEFAULT_NAN;
      if (is_inf(x) || is_inf(y)) return {x[31] ^ y[31], 8'hFF, 23'b0};
      return narrow(widen(x) * widen(y));
    endfunction

    function logic [31:0] fadd(logic [31:0] x, logic [31:0] y);
      if (is_nan(x)) return x | 32'h00400000;
      if (is_nan(y)) return y | 32'h00400000;
      if (is_inf(x) && is_inf(y) && x[31] != y[31]) return DEFAULT_NAN;
      if (is_inf(x)) return x;
      if (is_inf(y)) return y;
      return narrow(widen(x) + widen(y));
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
        CFG_ROW: rows_reg = val;
        CFG_INNER: inner_reg = val;
        CFG_COL: cols_reg = val;
        default: ;
      endcase
    endfunction

    // C += A * B, product rounded before each add, inner index ascending.
    function void multiply_accumulate();
      int m, n, kk;
      logic [31:0] acc;
      m = dim(rows_reg);
      n = dim(cols_reg);
      kk = dim(inner_reg);
      for (int i = 0; i < m; i++)
        for (int j = 0; j < n; j++) begin
          acc = c_mem[i * n + j];
          for (int k = 0; k < kk; k++)
            acc = fadd(acc, fmul(a_mem[i * kk + k], b_mem[k * n + j]));
          c_mem[i * n + j] = acc;
        end
    endfunction

    function void accept_beat(logic [2:0] fn, logic [7:0] idx, logic [31:0] val);
      case (fn)
        FN_LOAD_A: a_mem[idx] = val;
        FN_LOAD_B: b_mem[idx] = val;
        FN_LOAD_C: c_mem[idx] = val;
        FN_COMPUTE: multiply_accumulate();
        FN_READ_C: begin
          owed_value.push_back(c_mem[idx]);
          owed_index.push_back(idx);
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [31:0] value, logic [7:0] index);
      logic [31:0] want_value;
      logic [7:0] want_index;
      if (owed_value.size() == 0) begin
        $error("read beat with nothing owed: read_value %h read_index %0d", value, index);
        errors++;
        return;
      end
      want_value = owed_value.pop_front();
      want_index = owed_index.pop_front();
      if (value !== want_value) begin
        $error("read_value expected %h actual %h", want_value, value);
        errors++;
      end
      if (index !== want_index) begin
        $error("read_index expected %0d actual %0d", want_index, index);
        errors++;
      end
    endfunction

    function int owed();
      return owed_value.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [DIM_CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [7:0] elem_index = '0;
  logic [31:0] elem_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] read_value;
  logic [7:0] read_index;

  c_element_tracker tracker = new();
  bit c_loaded[STORE_WORDS];
  int beats_sent = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 52;
  int hold_request = 0;
  int hold_left = 0;
  int cycles = 0;

  matrix_multiply_accumulate i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .func, .elem_index, .elem_value,
    .out_valid, .out_stall, .read_value, .read_index
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** matrix_multiply_accumulate: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for one.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every accepted result beat against the oldest owed read.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_read(read_value, read_index);
  end

  // Shift idle pattern by thirds of the run: receiver lazy, then sender lazy, then none.
  function void update_idling();
    if (beats_sent < ITEM_GOAL / 3) begin
      send_idle_pct = 27;
      recv_idle_pct = 52;
    end else if (beats_sent < 2 * ITEM_GOAL / 3) begin
      send_idle_pct = 52;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Offer one beat, maybe after an idle gap, and hold it until accepted.
  task automatic send_beat(logic [2:0] fn, logic [7:0] idx, logic [31:0] val);
    int gap;
    update_idling();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    elem_index <= idx;
    elem_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.accept_beat(fn, idx, val);
    if (fn <= FN_READ_C) beats_sent++;
    if (fn == FN_LOAD_C) c_loaded[idx] = 1'b1;
  endtask

  // Stop offering and wait for every owed read to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_elem();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    if (pick < 78) return {1'($urandom), 31'b0};
    if (pick < 84) return {1'($urandom), 8'h00, 23'($urandom)};
    if (pick < 88) return {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'b0)};
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_loaded_c();
    logic [7:0] idx;
    idx = 8'($urandom);
    while (!c_loaded[idx]) idx = 8'($urandom);
    return idx;
  endfunction

  // One phase: set sizes while idle, fill the operands, compute, then a random mix.
  task automatic run_phase(logic [4:0] rv, logic [4:0] kv, logic [4:0] cv, int extra,
                           bit long_hold);
    int m, kk, n, pick;
    drain();
    write_reg(CFG_ROW, rv);
    write_reg(CFG_INNER, kv);
    write_reg(CFG_COL, cv);
    m = tracker.dim(rv);
    kk = tracker.dim(kv);
    n = tracker.dim(cv);
    for (int i = 0; i < m * kk; i++) send_beat(FN_LOAD_A, 8'(i), rand_elem());
    for (int i = 0; i < kk * n; i++) send_beat(FN_LOAD_B, 8'(i), rand_elem());
    for (int i = 0; i < m * n; i++) send_beat(FN_LOAD_C, 8'(i), rand_elem());
    send_beat(FN_COMPUTE, 8'($urandom), $urandom);
    if (long_hold) begin
      // Hold the receiver off past the compute while reads keep coming, so the block backs up.
      hold_request = 1000;
      repeat (40) send_beat(FN_READ_C, 8'($urandom_range(m * n - 1)), $urandom);
    end
    repeat (extra) begin
      pick = $urandom_range(99);
      if (pick < 55) send_beat(FN_READ_C, 8'($urandom_range(m * n - 1)), $urandom);
      else if (pick < 62) send_beat(FN_READ_C, rand_loaded_c(), $urandom);
      else if (pick < 82)
        send_beat(3'($urandom_range(FN_LOAD_A, FN_LOAD_C)), 8'($urandom), rand_elem());
      else if (pick < 92 && m * n * kk <= 64)
        send_beat(FN_COMPUTE, 8'($urandom), $urandom);
      else
        send_beat(3'($urandom_range(FN_SPARE_5, FN_SPARE_7)), 8'($urandom), $urandom);
    end
    // End on a read: its return means any compute has finished.
    send_beat(FN_READ_C, 8'($urandom_range(m * n - 1)), $urandom);
  endtask

  function automatic logic [4:0] rand_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) return 5'($urandom_range(1, 4));
    if (pick < 93) return 5'd0;
    return 5'($urandom_range(5, 6));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x1 times 1x2 with extreme values, spare codes, top index.
    write_reg(CFG_ROW, 5'd2);
    write_reg(CFG_INNER, 5'd1);
    write_reg(CFG_COL, 5'd2);
    write_reg(CFG_UNUSED, 5'd31);
    send_beat(FN_LOAD_A, 8'd0, 32'h7F7FFFFF);
    send_beat(FN_LOAD_A, 8'd1, 32'h00000001);
    send_beat(FN_LOAD_B, 8'd0, 32'h7F800000);
    send_beat(FN_LOAD_B, 8'd1, 32'h3F800000);
    send_beat(FN_LOAD_C, 8'd0, 32'hFF800000);
    send_beat(FN_LOAD_C, 8'd1, 32'h80000000);
    send_beat(FN_LOAD_C, 8'd2, 32'h7FC12345);
    send_beat(FN_LOAD_C, 8'd3, 32'h00000000);
    send_beat(FN_COMPUTE, 8'd255, 32'hFFFFFFFF);
    for (int i = 0; i < 4; i++) send_beat(FN_READ_C, 8'(i), 32'h0);
    send_beat(FN_SPARE_5, 8'd7, 32'h1);
    send_beat(FN_SPARE_6, 8'd8, 32'h2);
    send_beat(FN_SPARE_7, 8'd9, 32'h3);
    send_beat(FN_LOAD_C, 8'd255, 32'hFFFFFFFF);
    send_beat(FN_READ_C, 8'd255, 32'h0);
    send_beat(FN_LOAD_A, 8'd255, 32'h0);

    // Size extremes: 31 and 0 clamp to 16 and 1.
    run_phase(5'd31, 5'd0, 5'd1, 10, 1'b0);
    run_phase(5'd0, 5'd31, 5'd0, 10, 1'b0);
    run_phase(5'd3, 5'd2, 5'd4, 20, 1'b1);
    run_phase(5'd16, 5'd16, 5'd16, 30, 1'b0);
    while (beats_sent < ITEM_GOAL / 2)
      run_phase(rand_dim(), rand_dim(), rand_dim(), $urandom_range(10, 40), 1'b0);
    while (beats_sent < ITEM_GOAL)
      run_phase(rand_dim(), rand_dim(), rand_dim(), $urandom_range(10, 40), 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("** matrix_multiply_accumulate: PASSED **");
    end else begin
      $display("** matrix_multiply_accumulate: FAILED **");
    end
    $finish;
  end

endmodule
